// ===== sv/pds_pkg.sv =====
// shared types and constants for the projectile drag step block
package pds_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam logic MODE_SQRT = 1'b0;
  localparam logic MODE_DIV  = 1'b1;

  typedef struct packed {
    logic start;
    logic mode;
  } pds_cmd_t;

endpackage

// ===== sv/projectile_drag_step_core.sv =====
// top level: state, register file, sequencer and shared multiplier of the drag step
// A load item (func 1, 2 or 3) writes the body state and goes straight to the final state. A
// step item (func 0) runs a square root and a division, both on the shared bit-serial
// unit, plus sequencing and products through the one registered multiplier. The input
// is stalled while an item is in work. A finished beat goes to the output register once
// that register is free, so a stalled output holds the sequencer until then.
module projectile_drag_step_core #(
  parameter int FRAC_BITS = pds_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         func,
  input  logic signed [31:0] new_vx,
  input  logic signed [31:0] new_vy,
  input  logic signed [31:0] new_px,
  input  logic signed [31:0] new_py,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] vel_x,
  output logic signed [31:0] vel_y,
  output logic               saturated
);
  import pds_pkg::*;

  localparam logic [63:0] ONE_RST  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] GRAV_RST = ((64'd49 << FRAC_BITS) + 64'd2) / 64'd5;
  localparam logic [63:0] DT_RST   = ((64'd1 << FRAC_BITS) + 64'd5) / 64'd10;

  localparam logic [2:0] REG_DRAG = 3'd0;
  localparam logic [2:0] REG_MASS = 3'd1;
  localparam logic [2:0] REG_RAD  = 3'd2;
  localparam logic [2:0] REG_GRAV = 3'd3;
  localparam logic [2:0] REG_DT   = 3'd4;

  localparam logic [1:0] FN_STEP = 2'd0;
  localparam logic [1:0] FN_ALL  = 2'd1;
  localparam logic [1:0] FN_PX   = 2'd2;
  localparam logic [1:0] FN_PY   = 2'd3;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_SQX   = 5'd1;
  localparam logic [4:0] S_SQY   = 5'd2;
  localparam logic [4:0] S_SQGO  = 5'd3;
  localparam logic [4:0] S_SQW   = 5'd4;
  localparam logic [4:0] S_KR    = 5'd5;
  localparam logic [4:0] S_DVGO  = 5'd6;
  localparam logic [4:0] S_DVW   = 5'd7;
  localparam logic [4:0] S_CD    = 5'd8;
  localparam logic [4:0] S_AX    = 5'd9;
  localparam logic [4:0] S_AY    = 5'd10;
  localparam logic [4:0] S_AYG   = 5'd11;
  localparam logic [4:0] S_X1    = 5'd12;
  localparam logic [4:0] S_X2    = 5'd13;
  localparam logic [4:0] S_X3    = 5'd14;
  localparam logic [4:0] S_Y1    = 5'd15;
  localparam logic [4:0] S_Y2    = 5'd16;
  localparam logic [4:0] S_Y3    = 5'd17;
  localparam logic [4:0] S_FIN   = 5'd18;

  localparam logic signed [67:0] S32_MAX = 68'sd2147483647;
  localparam logic signed [67:0] S32_MIN = -68'sd2147483648;
  localparam logic signed [67:0] ADT_MAX = 68'sd4294967295;
  localparam logic signed [67:0] ADT_MIN = -68'sd4294967295;

  // configuration
  logic [30:0] drag_coef, body_mass, body_radius, gravity, time_step;
  // body state
  logic signed [31:0] px, py, vx, vy;
  logic [4:0]  state;
  logic        flg;

  // work registers
  logic signed [67:0] p;
  logic [63:0]        acc;
  logic [31:0]        speed, creg, dreg;
  logic signed [31:0] axr, ayr;
  logic signed [63:0] vdt;
  logic signed [32:0] adtr;

  logic signed [33:0] ma, mb;
  logic signed [67:0] ps, ps1, neg_s, ay_full, pos_sum, vel_sum;
  logic [31:0]        capv;
  logic               capo;
  logic signed [31:0] axs, ays, pnew, vnew;
  logic               axo, ayo, po, vo;
  logic signed [32:0] adtc;
  logic [30:0]        mass_eff;
  pds_cmd_t           cmd;
  logic               sdone;
  logic [63:0]        sres;
  logic [63:0]        soperand;
  logic               cfg_wr;
  logic               take;
  logic signed [31:0] ux_v;
  logic signed [33:0] ux, uy;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    case (paddr[4:2])
      REG_DRAG: prdata = {1'b0, drag_coef};
      REG_MASS: prdata = {1'b0, body_mass};
      REG_RAD:  prdata = {1'b0, body_radius};
      REG_GRAV: prdata = {1'b0, gravity};
      REG_DT:   prdata = {1'b0, time_step};
      default:  prdata = '0;
    endcase
  end

  assign mass_eff = (body_mass == '0) ? 31'd1 : body_mass;

  // magnitudes of the velocities
  assign ux_v = vx;
  assign ux = vx[31] ? -{{2{ux_v[31]}}, ux_v} : {{2{vx[31]}}, vx};
  assign uy = vy[31] ? -{{2{vy[31]}}, vy} : {{2{vy[31]}}, vy};

  // shifted product and its unsigned clamp
  assign ps   = p >>> FRAC_BITS;
  assign ps1  = p >>> (FRAC_BITS + 1);
  assign capo = |ps[67:32];
  assign capv = capo ? 32'hFFFF_FFFF : ps[31:0];

  assign neg_s   = (-p) >>> FRAC_BITS;
  assign axo     = (neg_s > S32_MAX) || (neg_s < S32_MIN);
  assign axs     = (neg_s > S32_MAX) ? 32'sh7FFF_FFFF :
                   (neg_s < S32_MIN) ? 32'sh8000_0000 : neg_s[31:0];
  assign ay_full = neg_s - $signed({37'b0, gravity});
  assign ayo     = (ay_full > S32_MAX) || (ay_full < S32_MIN);
  assign ays     = (ay_full > S32_MAX) ? 32'sh7FFF_FFFF :
                   (ay_full < S32_MIN) ? 32'sh8000_0000 : ay_full[31:0];

  // a*dt limited silently
  assign adtc = (ps > ADT_MAX) ? 33'sh0_FFFF_FFFF :
                (ps < ADT_MIN) ? -33'sh0_FFFF_FFFF : ps[32:0];

  // position and velocity updates, shared by both axes
  always_comb begin
    if (state == S_X3) begin
      pos_sum = {{36{px[31]}}, px} + {{4{vdt[63]}}, vdt} + ps1;
      vel_sum = {{36{vx[31]}}, vx} + {{35{adtr[32]}}, adtr};
    end else begin
      pos_sum = {{36{py[31]}}, py} + {{4{vdt[63]}}, vdt} + ps1;
      vel_sum = {{36{vy[31]}}, vy} + {{35{adtr[32]}}, adtr};
    end
    po   = (pos_sum > S32_MAX) || (pos_sum < S32_MIN);
    vo   = (vel_sum > S32_MAX) || (vel_sum < S32_MIN);
    pnew = (pos_sum > S32_MAX) ? 32'sh7FFF_FFFF :
           (pos_sum < S32_MIN) ? 32'sh8000_0000 : pos_sum[31:0];
    vnew = (vel_sum > S32_MAX) ? 32'sh7FFF_FFFF :
           (vel_sum < S32_MIN) ? 32'sh8000_0000 : vel_sum[31:0];
  end

  // operand select of the shared multiplier
  always_comb begin
    ma = '0;
    mb = '0;
    case (state)
      S_SQX: begin
        ma = ux;
        mb = ux;
      end
      S_SQY: begin
        ma = uy;
        mb = uy;
      end
      S_SQGO, S_SQW: begin
        ma = {3'b0, body_radius};
        mb = {3'b0, body_radius};
      end
      S_KR: begin
        ma = {3'b0, drag_coef};
        mb = {2'b0, capv};
      end
      S_CD: begin
        ma = {2'b0, creg};
        mb = {2'b0, speed};
      end
      S_AX: begin
        ma = {2'b0, capv};
        mb = {{2{vx[31]}}, vx};
      end
      S_AY: begin
        ma = {2'b0, dreg};
        mb = {{2{vy[31]}}, vy};
      end
      S_AYG: begin
        ma = {{2{vx[31]}}, vx};
        mb = {3'b0, time_step};
      end
      S_X1: begin
        ma = {{2{axr[31]}}, axr};
        mb = {3'b0, time_step};
      end
      S_X2, S_Y2: begin
        ma = {adtc[32], adtc};
        mb = {3'b0, time_step};
      end
      S_X3: begin
        ma = {{2{vy[31]}}, vy};
        mb = {3'b0, time_step};
      end
      S_Y1: begin
        ma = {{2{ayr[31]}}, ayr};
        mb = {3'b0, time_step};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_comb begin
    cmd.start = 1'b0;
    cmd.mode  = MODE_SQRT;
    soperand  = acc + p[63:0];
    if (state == S_SQGO) begin
      cmd.start = 1'b1;
    end else if (state == S_DVGO) begin
      cmd.start = 1'b1;
      cmd.mode  = MODE_DIV;
      soperand  = {32'b0, capv} << FRAC_BITS;
    end
  end

  pds_serial #(.FRAC_BITS(FRAC_BITS)) u_serial (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .operand (soperand),
    .divisor (mass_eff),
    .done    (sdone),
    .result  (sres)
  );

  assign in_stall = (state != S_IDLE);
  assign take     = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    p <= ma * mb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      drag_coef   <= '0;
      body_mass   <= ONE_RST[30:0];
      body_radius <= ONE_RST[30:0];
      gravity     <= GRAV_RST[30:0];
      time_step   <= DT_RST[30:0];
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_DRAG: drag_coef   <= pwdata[30:0];
        REG_MASS: body_mass   <= pwdata[30:0];
        REG_RAD:  body_radius <= pwdata[30:0];
        REG_GRAV: gravity     <= pwdata[30:0];
        REG_DT:   time_step   <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      px        <= '0;
      py        <= '0;
      vx        <= '0;
      vy        <= '0;
      flg       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall && state != S_FIN) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (take) begin
            flg <= 1'b0;
            case (func)
              FN_STEP: state <= S_SQX;
              FN_ALL: begin
                vx <= new_vx;
                vy <= new_vy;
                px <= new_px;
                py <= new_py;
                state <= S_FIN;
              end
              FN_PX: begin
                px <= new_px;
                state <= S_FIN;
              end
              FN_PY: begin
                py <= new_py;
                state <= S_FIN;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_SQX: state <= S_SQY;
        S_SQY: begin
          acc   <= p[63:0];
          state <= S_SQGO;
        end
        S_SQGO: state <= S_SQW;
        S_SQW: begin
          if (sdone) begin
            speed <= sres[31:0];
            state <= S_KR;
          end
        end
        S_KR: begin
          // radius squared
          if (capo) flg <= 1'b1;
          state <= S_DVGO;
        end
        S_DVGO: begin
          if (capo) flg <= 1'b1;
          state <= S_DVW;
        end
        S_DVW: begin
          if (sdone) begin
            if (|sres[63:32]) begin
              flg  <= 1'b1;
              creg <= 32'hFFFF_FFFF;
            end else begin
              creg <= sres[31:0];
            end
            state <= S_CD;
          end
        end
        S_CD: state <= S_AX;
        S_AX: begin
          if (capo) flg <= 1'b1;
          dreg  <= capv;
          state <= S_AY;
        end
        S_AY: begin
          if (axo) flg <= 1'b1;
          axr   <= axs;
          state <= S_AYG;
        end
        S_AYG: begin
          if (ayo) flg <= 1'b1;
          ayr   <= ays;
          state <= S_X1;
        end
        S_X1, S_Y1: begin
          vdt   <= ps[63:0];
          state <= (state == S_X1) ? S_X2 : S_Y2;
        end
        S_X2, S_Y2: begin
          adtr  <= adtc;
          state <= (state == S_X2) ? S_X3 : S_Y3;
        end
        S_X3: begin
          if (po || vo) flg <= 1'b1;
          px    <= pnew;
          vx    <= vnew;
          state <= S_Y1;
        end
        S_Y3: begin
          if (po || vo) flg <= 1'b1;
          py    <= pnew;
          vy    <= vnew;
          state <= S_FIN;
        end
        S_FIN: begin
          // hand over the beat once the output register is free
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            pos_x     <= px;
            pos_y     <= py;
            vel_x     <= vx;
            vel_y     <= vy;
            saturated <= flg;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/pds_serial.sv =====
// shared bit-serial unit: integer square root or restoring division, one bit a cycle
module pds_serial #(
  parameter int FRAC_BITS = pds_pkg::FRAC_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  pds_pkg::pds_cmd_t cmd,
  input  logic [63:0]      operand,
  input  logic [30:0]      divisor,
  output logic             done,
  output logic [63:0]      result
);
  import pds_pkg::*;

  localparam int DW = 32 + FRAC_BITS;
  localparam int CW = $clog2(DW);

  logic          busy;
  logic          mode;
  logic [CW-1:0] cnt;
  logic [63:0]   x;
  logic [35:0]   rem;
  logic [63:0]   root;
  logic [35:0]   sh;
  logic [35:0]   trial;
  logic [36:0]   diff;
  logic          ge;

  always_comb begin
    if (mode == MODE_SQRT) begin
      sh    = {rem[33:0], x[63:62]};
      trial = {2'b00, root[31:0], 2'b01};
    end else begin
      sh    = {rem[34:0], x[63]};
      trial = {5'b0, divisor};
    end
    diff = {1'b0, sh} - {1'b0, trial};
    ge   = ~diff[36];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        mode <= cmd.mode;
        rem  <= '0;
        root <= '0;
        if (cmd.mode == MODE_SQRT) begin
          x   <= operand;
          cnt <= CW'(31);
        end else begin
          // align the dividend to the top so bits come out msb first
          x   <= operand << (64 - DW);
          cnt <= CW'(DW - 1);
        end
      end else if (busy) begin
        rem  <= ge ? diff[35:0] : sh;
        root <= {root[62:0], ge};
        x    <= (mode == MODE_SQRT) ? {x[61:0], 2'b00} : {x[62:0], 1'b0};
        cnt  <= cnt - CW'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = root;

endmodule
